// File: hw/rtl/fcn_pkg.sv
// ----------------------------------------------------------------------------
// fcn_pkg
// Shared types and constants for the normalized multichannel FIR filter.
// ----------------------------------------------------------------------------
package fcn_pkg;

  localparam int DEF_MAX_TAPS = 64;
  localparam int DEF_CHANNELS = 2;

  localparam int SAMPLE_W  = 16;  // sample and coefficient width
  localparam int Q_W       = 16;  // quotient magnitude bits
  localparam int TAP_CNT_W = 7;
  localparam int TAP_IDX_W = 6;
  localparam int REQ_W     = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH,
    S_READ,
    S_DRAIN,
    S_DIV,
    S_EMIT,
    S_WIPE
  } state_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
  } div_res_t;

endpackage

// File: hw/rtl/fcn_store.sv
// ----------------------------------------------------------------------------
// fcn_store
// Coefficient memory and per-channel delay line memory, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module fcn_store #(
  parameter int MAX_TAPS = fcn_pkg::DEF_MAX_TAPS,
  parameter int CHANNELS = fcn_pkg::DEF_CHANNELS,
  localparam int CW = $clog2(MAX_TAPS),
  localparam int HW = $clog2(CHANNELS * MAX_TAPS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                coef_we,
  input  logic [CW-1:0]                       coef_waddr,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0] coef_wdata,
  input  logic                                hist_we,
  input  logic [HW-1:0]                       hist_waddr,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0] hist_wdata,
  input  logic                                rd_en,
  input  logic [CW-1:0]                       coef_raddr,
  input  logic [HW-1:0]                       hist_raddr,
  output logic signed [fcn_pkg::SAMPLE_W-1:0] rd_coef,
  output logic signed [fcn_pkg::SAMPLE_W-1:0] rd_hist,
  output logic                                rd_vld
);

  logic signed [fcn_pkg::SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic signed [fcn_pkg::SAMPLE_W-1:0] hist_mem [CHANNELS * MAX_TAPS];
  logic signed [fcn_pkg::SAMPLE_W-1:0] rd_coef_r;
  logic signed [fcn_pkg::SAMPLE_W-1:0] rd_hist_r;
  logic                                rd_vld_r;

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_coef_r <= coef_mem[coef_raddr];
      rd_hist_r <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  assign rd_coef = rd_coef_r;
  assign rd_hist = rd_hist_r;
  assign rd_vld  = rd_vld_r;

endmodule

// File: hw/rtl/fcn_mac.sv
// ----------------------------------------------------------------------------
// fcn_mac
// Multiply-accumulate pipeline: registered product and coefficient magnitude,
// then running sums of products and of magnitudes.
// ----------------------------------------------------------------------------
module fcn_mac #(
  parameter int MAX_TAPS = fcn_pkg::DEF_MAX_TAPS,
  localparam int LG    = $clog2(MAX_TAPS),
  localparam int ACC_W = 2 * fcn_pkg::SAMPLE_W + LG,
  localparam int DEN_W = fcn_pkg::SAMPLE_W + LG
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                in_vld,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0] coef,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0] hist,
  output logic signed [ACC_W-1:0]             acc,
  output logic [DEN_W-1:0]                    den,
  output logic                                busy
);

  localparam int PW = 2 * fcn_pkg::SAMPLE_W;

  logic signed [PW-1:0]                 prod_r;
  logic [fcn_pkg::SAMPLE_W-1:0]         mag_r;
  logic                                 prod_vld_r;
  logic signed [ACC_W-1:0]              acc_r;
  logic [DEN_W-1:0]                     den_r;
  logic signed [fcn_pkg::SAMPLE_W:0]    coef_ext;
  logic signed [fcn_pkg::SAMPLE_W:0]    coef_abs;

  // magnitude of -32768 still fits in 16 unsigned bits
  always_comb begin
    coef_ext = (fcn_pkg::SAMPLE_W + 1)'(coef);
    coef_abs = (coef_ext < 0) ? -coef_ext : coef_ext;
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      prod_r <= coef * hist;
      mag_r  <= coef_abs[fcn_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
      den_r      <= '0;
    end else begin
      prod_vld_r <= in_vld;
      if (clr) begin
        acc_r <= '0;
        den_r <= '0;
      end else if (prod_vld_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
        den_r <= den_r + DEN_W'(mag_r);
      end
    end
  end

  assign acc  = acc_r;
  assign den  = den_r;
  assign busy = in_vld | prod_vld_r;

endmodule

// File: hw/rtl/fcn_div.sv
// ----------------------------------------------------------------------------
// fcn_div
// Serial restoring divider, one quotient bit a cycle, truncating toward zero
// and saturating positive results to the sample maximum; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module fcn_div #(
  parameter int MAX_TAPS = fcn_pkg::DEF_MAX_TAPS,
  localparam int LG    = $clog2(MAX_TAPS),
  localparam int ACC_W = 2 * fcn_pkg::SAMPLE_W + LG,
  localparam int DEN_W = fcn_pkg::SAMPLE_W + LG
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output fcn_pkg::div_res_t       res
);

  localparam int QW    = fcn_pkg::Q_W;
  localparam int CNT_W = $clog2(QW);

  logic [ACC_W-1:0]               rem_r;
  logic [ACC_W-1:0]               dvs_r;
  logic [QW-1:0]                  q_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           busy_r;
  logic                           neg_r;
  logic                           zero_r;
  logic                           done_r;
  logic signed [fcn_pkg::SAMPLE_W-1:0] val_r;

  logic [ACC_W-1:0]               num_mag;
  logic                           ge;
  logic [QW-1:0]                  q_nxt;
  logic signed [QW:0]             sres;
  logic signed [fcn_pkg::SAMPLE_W-1:0] val_nxt;

  always_comb begin
    num_mag = (num < 0) ? -num : num;
    ge      = (rem_r >= dvs_r);
    q_nxt   = {q_r[QW-2:0], ge};
    sres    = neg_r ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
    if (zero_r) begin
      val_nxt = '0;
    end else if (!neg_r && q_nxt[QW-1]) begin
      val_nxt = {1'b0, {(fcn_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      val_nxt = sres[fcn_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_mag;
      dvs_r  <= ACC_W'(den) << (QW - 1);
      q_r    <= '0;
      neg_r  <= (num < 0);
      zero_r <= (den == '0);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
      q_r   <= q_nxt;
    end
    if (busy_r && cnt_r == '0) begin
      val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = val_r;

endmodule

// File: hw/rtl/fir_convolution_normalized.sv
// ----------------------------------------------------------------------------
// fir_convolution_normalized
// Sample path: each accepted sample is read one tap a cycle through the
// coefficient/history read port, then normalized by a serial divide before
// out_valid. One item at a time; a load writes its coefficient and stays idle.
// A flush runs (tap_count-1) such passes, then wipes the delay line. After
// reset both memories are cleared with in_ready low; configuration writes
// are still taken.
// ----------------------------------------------------------------------------
module fir_convolution_normalized #(
  parameter int MAX_TAPS = fcn_pkg::DEF_MAX_TAPS,
  parameter int CHANNELS = fcn_pkg::DEF_CHANNELS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fcn_pkg::TAP_CNT_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fcn_pkg::REQ_W-1:0]            in_req_type,
  input  logic                                 in_channel,
  input  logic [fcn_pkg::TAP_IDX_W-1:0]        in_tap_index,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0]  in_coefficient,
  input  logic signed [fcn_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_channel,
  output logic signed [fcn_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_last
);

  localparam int CW    = $clog2(MAX_TAPS);
  localparam int HW    = $clog2(CHANNELS * MAX_TAPS);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LG    = $clog2(MAX_TAPS);
  localparam int ACC_W = 2 * fcn_pkg::SAMPLE_W + LG;
  localparam int DEN_W = fcn_pkg::SAMPLE_W + LG;
  localparam int SW    = fcn_pkg::SAMPLE_W;

  fcn_pkg::state_t state_r, state_nxt;

  logic [fcn_pkg::TAP_CNT_W-1:0] tap_count_r;
  logic                          ch_r, ch_nxt;
  logic signed [SW-1:0]          x_r, x_nxt;
  logic                          is_flush_r, is_flush_nxt;
  logic [CW-1:0]                 tail_r, tail_nxt;
  logic [CW-1:0]                 m_r, m_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic [HW-1:0]                 clr_r, clr_nxt;
  logic [CW-1:0]                 wpos_r [CHANNELS];
  logic [CW-1:0]                 wpos_nxt [CHANNELS];

  logic                          out_valid_r;
  logic                          out_channel_r;
  logic signed [SW-1:0]          out_sample_r;
  logic                          out_last_r;

  logic                          in_fire;
  logic                          ch_ok;
  logic                          idx_ok;
  logic [CW-1:0]                 taps_m1;
  logic [CW-1:0]                 cur_wpos;
  logic [HW-1:0]                 hist_base;
  logic                          out_free;
  logic                          run_last;
  logic                          clr_done;

  // store / datapath controls
  logic                          coef_we;
  logic [CW-1:0]                 coef_waddr;
  logic signed [SW-1:0]          coef_wdata;
  logic                          hist_we;
  logic [HW-1:0]                 hist_waddr;
  logic signed [SW-1:0]          hist_wdata;
  logic                          rd_en;
  logic [HW-1:0]                 hist_raddr;
  logic signed [SW-1:0]          rd_coef;
  logic signed [SW-1:0]          rd_hist;
  logic                          rd_vld;
  logic                          mac_clr;
  logic                          mac_busy;
  logic signed [ACC_W-1:0]       acc;
  logic [DEN_W-1:0]              den;
  logic                          div_start;
  logic                          out_load;
  fcn_pkg::div_res_t             div_res;

  // taps in use, zero reads as one and large values clamp to MAX_TAPS
  always_comb begin
    if (tap_count_r == '0) begin
      taps_m1 = '0;
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      taps_m1 = CW'(MAX_TAPS - 1);
    end else begin
      taps_m1 = CW'(tap_count_r - 1'b1);
    end
  end

  assign in_fire   = in_valid & in_ready;
  assign ch_ok     = 32'(in_channel) < CHANNELS;
  assign idx_ok    = 32'(in_tap_index) < MAX_TAPS;
  assign cur_wpos  = wpos_r[CHW'(ch_r)];
  assign hist_base = HW'(ch_r) * HW'(MAX_TAPS);
  assign out_free  = !out_valid_r || out_ready;
  assign run_last  = !is_flush_r || (tail_r == CW'(1));
  assign clr_done  = (clr_r == HW'(CHANNELS * MAX_TAPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcn_pkg::S_CLEAR: begin
        if (clr_done) state_nxt = fcn_pkg::S_IDLE;
      end
      fcn_pkg::S_IDLE: begin
        if (in_fire && ch_ok) begin
          if (in_req_type == fcn_pkg::REQ_SAMPLE) begin
            state_nxt = fcn_pkg::S_PUSH;
          end else if (in_req_type == fcn_pkg::REQ_FLUSH) begin
            state_nxt = (taps_m1 == '0) ? fcn_pkg::S_WIPE : fcn_pkg::S_PUSH;
          end
        end
      end
      fcn_pkg::S_PUSH: state_nxt = fcn_pkg::S_READ;
      fcn_pkg::S_READ: begin
        if (m_r == taps_m1) state_nxt = fcn_pkg::S_DRAIN;
      end
      fcn_pkg::S_DRAIN: begin
        if (!mac_busy) state_nxt = fcn_pkg::S_DIV;
      end
      fcn_pkg::S_DIV: begin
        if (div_res.done) state_nxt = fcn_pkg::S_EMIT;
      end
      fcn_pkg::S_EMIT: begin
        if (out_free) begin
          if (!is_flush_r) begin
            state_nxt = fcn_pkg::S_IDLE;
          end else if (run_last) begin
            state_nxt = fcn_pkg::S_WIPE;
          end else begin
            state_nxt = fcn_pkg::S_PUSH;
          end
        end
      end
      fcn_pkg::S_WIPE: begin
        if (m_r == CW'(MAX_TAPS - 1)) state_nxt = fcn_pkg::S_IDLE;
      end
      default: state_nxt = fcn_pkg::S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    coef_we    = 1'b0;
    coef_waddr = CW'(in_tap_index);
    coef_wdata = in_coefficient;
    hist_we    = 1'b0;
    hist_waddr = hist_base + HW'(cur_wpos);
    hist_wdata = x_r;
    rd_en      = 1'b0;
    hist_raddr = hist_base + HW'(idx_r);
    mac_clr    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      fcn_pkg::S_CLEAR: begin
        coef_we    = 32'(clr_r) < MAX_TAPS;
        coef_waddr = CW'(clr_r);
        coef_wdata = '0;
        hist_we    = 1'b1;
        hist_waddr = clr_r;
        hist_wdata = '0;
      end
      fcn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        coef_we  = in_fire && (in_req_type == fcn_pkg::REQ_LOAD) && idx_ok;
      end
      fcn_pkg::S_PUSH: begin
        hist_we = 1'b1;
        mac_clr = 1'b1;
      end
      fcn_pkg::S_READ: rd_en = 1'b1;
      fcn_pkg::S_DRAIN: div_start = !mac_busy;
      fcn_pkg::S_DIV: ;
      fcn_pkg::S_EMIT: out_load = out_free;
      fcn_pkg::S_WIPE: begin
        hist_we    = 1'b1;
        hist_waddr = hist_base + HW'(m_r);
        hist_wdata = '0;
      end
      default: ;
    endcase
  end

  // counters and item context
  always_comb begin
    ch_nxt       = ch_r;
    x_nxt        = x_r;
    is_flush_nxt = is_flush_r;
    tail_nxt     = tail_r;
    m_nxt        = m_r;
    idx_nxt      = idx_r;
    clr_nxt      = clr_r;
    wpos_nxt     = wpos_r;
    case (state_r)
      fcn_pkg::S_CLEAR: clr_nxt = clr_r + 1'b1;
      fcn_pkg::S_IDLE: begin
        if (in_fire) begin
          ch_nxt       = in_channel;
          is_flush_nxt = (in_req_type == fcn_pkg::REQ_FLUSH);
          x_nxt        = (in_req_type == fcn_pkg::REQ_FLUSH) ? '0 : in_sample;
          tail_nxt     = taps_m1;
          m_nxt        = '0;
        end
      end
      fcn_pkg::S_PUSH: begin
        idx_nxt = cur_wpos;
        m_nxt   = '0;
        wpos_nxt[CHW'(ch_r)] = (cur_wpos == CW'(MAX_TAPS - 1)) ? '0 : cur_wpos + 1'b1;
      end
      fcn_pkg::S_READ: begin
        m_nxt   = m_r + 1'b1;
        idx_nxt = (idx_r == '0) ? CW'(MAX_TAPS - 1) : idx_r - 1'b1;
      end
      fcn_pkg::S_EMIT: begin
        if (out_free) begin
          tail_nxt = tail_r - 1'b1;
          m_nxt    = '0;
        end
      end
      fcn_pkg::S_WIPE: begin
        m_nxt = m_r + 1'b1;
        if (m_r == CW'(MAX_TAPS - 1)) begin
          wpos_nxt[CHW'(ch_r)] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcn_pkg::S_CLEAR;
      tap_count_r <= fcn_pkg::TAP_CNT_W'(1);
      clr_r       <= '0;
      is_flush_r  <= 1'b0;
      tail_r      <= '0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wpos_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      is_flush_r <= is_flush_nxt;
      tail_r     <= tail_nxt;
      m_r        <= m_nxt;
      wpos_r     <= wpos_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r  <= ch_nxt;
    x_r   <= x_nxt;
    idx_r <= idx_nxt;
    if (out_load) begin
      out_channel_r <= ch_r;
      out_sample_r  <= div_res.value;
      out_last_r    <= run_last;
    end
  end

  fcn_store #(
    .MAX_TAPS (MAX_TAPS),
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .rd_en      (rd_en),
    .coef_raddr (m_r),
    .hist_raddr (hist_raddr),
    .rd_coef    (rd_coef),
    .rd_hist    (rd_hist),
    .rd_vld     (rd_vld)
  );

  fcn_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mac_clr),
    .in_vld (rd_vld),
    .coef   (rd_coef),
    .hist   (rd_hist),
    .acc    (acc),
    .den    (den),
    .busy   (mac_busy)
  );

  fcn_div #(
    .MAX_TAPS (MAX_TAPS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc),
    .den   (den),
    .res   (div_res)
  );

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_sample  = out_sample_r;
  assign out_last    = out_last_r;

  // divider result only arrives while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == fcn_pkg::S_DIV)
    else $error("divider finished outside of divide wait");

  // accumulator is cleared only with an empty product pipeline
  a_clr_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mac_clr |-> !mac_busy)
    else $error("accumulator cleared while taps still in flight");

  // a waiting beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while holding an untaken beat");

  // a flush run never pushes with nothing left to emit
  a_tail_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcn_pkg::S_PUSH && is_flush_r) |-> tail_r != '0)
    else $error("flush tail counter underflow");

  // delay line is never written while taps are being read
  a_no_wr_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !hist_we && $past(state_r) != fcn_pkg::S_IDLE)
    else $error("history write overlaps a tap read");

endmodule
